// ===== rtl/gim_pkg.sv =====
package gim_pkg;

  localparam int MaxWidth = 64;
  localparam int WidthBits = 7;
  localparam int ColBits = 6;
  localparam int PosBits = 3;
  localparam int LaneCnt = 8;

  localparam logic [WidthBits-1:0] WIDTH_RESET = 7'd8;
  localparam logic [WidthBits-1:0] WIDTH_MAX = 7'(MaxWidth);

  // register word addresses
  localparam logic REG_GLYPH_WIDTH = 1'b0;

  localparam logic [20:0] CP_WS_LO = 21'h02000;
  localparam logic [20:0] CP_WS_HI = 21'h0200F;
  localparam logic [20:0] CP_ASCII_HI = 21'h0007F;
  localparam logic [20:0] CP_CJK_LO = 21'h02E80;
  localparam logic [20:0] CP_CJK_HI = 21'h09FFF;
  localparam logic [20:0] CP_KANA_LO = 21'h03000;
  localparam logic [20:0] CP_KANA_HI = 21'h030FF;
  localparam logic [20:0] CP_COMPAT_LO = 21'h0F900;
  localparam logic [20:0] CP_COMPAT_HI = 21'h0FAFF;
  localparam logic [20:0] CP_FULL_LO = 21'h0FF00;
  localparam logic [20:0] CP_FULL_HI = 21'h0FF60;
  localparam logic [20:0] CP_EM_SPACE = 21'h02003;
  localparam logic [20:0] CP_EN_SPACE = 21'h02002;
  localparam logic [20:0] CP_IDEO_SPACE = 21'h03000;

  typedef struct packed {
    logic hit;
    logic [ColBits-1:0] lo_col;
    logic [ColBits-1:0] hi_col;
  } byte_ink_t;

  typedef struct packed {
    logic not_found;
    logic is_empty;
    logic [ColBits-1:0] left_ink;
    logic [WidthBits-1:0] advance;
  } glyph_res_t;

  // floor(w/3) for w below 128, reciprocal multiply
  function automatic logic [WidthBits-1:0] div3(input logic [WidthBits-1:0] w);
    logic [13:0] prod;
    prod = 14'(w) * 14'd43;
    return prod[13:7];
  endfunction

endpackage

// ===== rtl/glyph_ink_metrics_unit.sv =====
// glyph ink metrics unit
// the input channel carries one bitmap byte per word, row by row, each row
// ceil(width/8) bytes, msb leftmost; code_point and read_ok are sampled on
// the word flagged last_byte, which ends the glyph
// the result channel gives one word per glyph: not_found, is_empty,
// left_ink and advance
// eight pixel lanes test one byte per cycle and a merge stage folds the
// inked columns into the running min/max, so one byte is taken every
// cycle but for a held last byte; the result appears in the cycle after
// its last byte is accepted and sits in an output register; while it
// waits, bytes that are not the last of a glyph are still taken, a last
// byte waits until the register is free or is being emptied in the same cycle
// glyph width is written over the apb port at byte address 0 (reset 8;
// bits 6:0 kept, values 65 to 127 act as 64); write it between glyphs or rows
// synchronous active-low reset clears the scan state and the output valid
module glyph_ink_metrics_unit
  import gim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_byte,
  input  logic [20:0] in_code_point,
  input  logic        in_read_ok,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_not_found,
  output logic        out_is_empty,
  output logic [5:0]  out_left_ink,
  output logic [6:0]  out_advance
);

  logic [WidthBits-1:0] glyph_width_r;
  logic [PosBits-1:0]   row_byte_pos_r, row_byte_pos_nxt;
  logic [WidthBits-1:0] min_col_r, min_col_nxt;
  logic [ColBits-1:0]   max_col_r, max_col_nxt;
  logic                 ink_seen_r, ink_seen_nxt;
  logic                 out_valid_r;
  glyph_res_t           res_r;

  logic [WidthBits-1:0] eff_w;
  logic [3:0]           bpr;
  logic [PosBits-1:0]   pos;
  logic [3:0]           pos_inc;
  logic [LaneCnt-1:0]   lane_hit;
  byte_ink_t            ink;
  glyph_res_t           res;
  logic                 in_fire;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_GLYPH_WIDTH) ? {25'd0, glyph_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r <= WIDTH_RESET;
    end else if (cfg_wr && (paddr[2] == REG_GLYPH_WIDTH)) begin
      glyph_width_r <= pwdata[WidthBits-1:0];
    end
  end

  assign eff_w = (glyph_width_r > WIDTH_MAX) ? WIDTH_MAX : glyph_width_r;

  always_comb begin
    bpr = 4'((eff_w + WidthBits'(7)) >> 3);
    if (bpr == 4'd0) bpr = 4'd1;
  end

  // a width change may leave the row position past the row end
  assign pos = ({1'b0, row_byte_pos_r} >= bpr) ? '0 : row_byte_pos_r;
  assign pos_inc = {1'b0, pos} + 4'd1;

  for (genvar i = 0; i < LaneCnt; i++) begin : g_lane
    gim_lane u_lane (
      .lane_idx(PosBits'(i)),
      .row_pos (pos),
      .pixel   (in_pixel_byte[LaneCnt-1-i]),
      .width   (eff_w),
      .hit     (lane_hit[i])
    );
  end

  gim_merge u_merge (
    .lane_hit(lane_hit),
    .row_pos (pos),
    .ink     (ink)
  );

  always_comb begin
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    if (ink.hit) begin
      if (!ink_seen_r || ({1'b0, ink.lo_col} < min_col_r)) min_col_nxt = {1'b0, ink.lo_col};
      if (!ink_seen_r || (ink.hi_col > max_col_r)) max_col_nxt = ink.hi_col;
    end
    ink_seen_nxt = ink_seen_r || ink.hit;
    row_byte_pos_nxt = (pos_inc >= bpr) ? '0 : pos_inc[PosBits-1:0];
  end

  gim_result u_result (
    .ink_seen  (ink_seen_nxt),
    .min_col   (min_col_nxt),
    .max_col   (max_col_nxt),
    .code_point(in_code_point),
    .read_ok   (in_read_ok),
    .width     (eff_w),
    .res       (res)
  );

  assign in_ready = !in_last_byte || !out_valid_r || out_ready;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_byte_pos_r <= '0;
      min_col_r <= WIDTH_RESET;
      max_col_r <= '0;
      ink_seen_r <= 1'b0;
    end else if (in_fire) begin
      if (in_last_byte) begin
        row_byte_pos_r <= '0;
        min_col_r <= eff_w;
        max_col_r <= '0;
        ink_seen_r <= 1'b0;
      end else begin
        row_byte_pos_r <= row_byte_pos_nxt;
        min_col_r <= min_col_nxt;
        max_col_r <= max_col_nxt;
        ink_seen_r <= ink_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_not_found = res_r.not_found;
  assign out_is_empty = res_r.is_empty;
  assign out_left_ink = res_r.left_ink;
  assign out_advance = res_r.advance;

  a_ink_order: assert property (@(posedge clk) disable iff (!rst_n)
    ink_seen_r |-> ({1'b0, max_col_r} >= min_col_r))
    else $error("max column below min column");

  a_inked_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> !out_not_found)
    else $error("inked glyph flagged not found");

  a_empty_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_left_ink == '0))
    else $error("empty glyph with nonzero left column");

  a_glyph_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (!ink_seen_r && (row_byte_pos_r == '0) && out_valid_r))
    else $error("scan state not cleared after last byte");

endmodule

// ===== rtl/gim_lane.sv =====
module gim_lane
  import gim_pkg::*;
(
  input  logic [PosBits-1:0]   lane_idx,
  input  logic [PosBits-1:0]   row_pos,
  input  logic                 pixel,
  input  logic [WidthBits-1:0] width,
  output logic                 hit
);

  logic [ColBits-1:0] col;

  assign col = {row_pos, lane_idx};
  assign hit = pixel && ({1'b0, col} < width);

endmodule

// ===== rtl/gim_merge.sv =====
module gim_merge
  import gim_pkg::*;
(
  input  logic [LaneCnt-1:0] lane_hit,
  input  logic [PosBits-1:0] row_pos,
  output byte_ink_t          ink
);

  logic [PosBits-1:0] lo_idx;
  logic [PosBits-1:0] hi_idx;

  // lane 0 is the leftmost pixel
  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    for (int i = LaneCnt - 1; i >= 0; i--) begin
      if (lane_hit[i]) lo_idx = PosBits'(i);
    end
    for (int i = 0; i < LaneCnt; i++) begin
      if (lane_hit[i]) hi_idx = PosBits'(i);
    end
  end

  assign ink.hit = |lane_hit;
  assign ink.lo_col = {row_pos, lo_idx};
  assign ink.hi_col = {row_pos, hi_idx};

endmodule

// ===== rtl/gim_result.sv =====
module gim_result
  import gim_pkg::*;
(
  input  logic                 ink_seen,
  input  logic [WidthBits-1:0] min_col,
  input  logic [ColBits-1:0]   max_col,
  input  logic [20:0]          code_point,
  input  logic                 read_ok,
  input  logic [WidthBits-1:0] width,
  output glyph_res_t           res
);

  logic empty;
  logic ws;
  logic full;
  logic [WidthBits:0] content;

  assign empty = !read_ok || !ink_seen;
  assign ws = (code_point >= CP_WS_LO) && (code_point <= CP_WS_HI);
  assign full = ((code_point >= CP_CJK_LO) && (code_point <= CP_CJK_HI)) ||
                ((code_point >= CP_KANA_LO) && (code_point <= CP_KANA_HI)) ||
                ((code_point >= CP_COMPAT_LO) && (code_point <= CP_COMPAT_HI)) ||
                ((code_point >= CP_FULL_LO) && (code_point <= CP_FULL_HI));
  assign content = {2'b00, max_col} - {1'b0, min_col} + (WidthBits+1)'(3);

  always_comb begin
    res.not_found = !read_ok || (empty && !ws && (code_point > CP_ASCII_HI));
    res.is_empty = empty;
    res.left_ink = empty ? '0 : min_col[ColBits-1:0];
    if (!empty) begin
      if (full) res.advance = width;
      else if (content > {1'b0, width}) res.advance = width;
      else res.advance = content[WidthBits-1:0];
    end else if (ws) begin
      if (code_point == CP_EM_SPACE) res.advance = width;
      else if (code_point == CP_EN_SPACE) res.advance = width >> 1;
      // ideographic space sits outside the space range, never taken
      else if (code_point == CP_IDEO_SPACE) res.advance = width;
      else res.advance = div3(width);
    end else begin
      res.advance = div3(width);
    end
  end

endmodule

// ===== dv/glyph_ink_metrics_unit_test.sv =====
module glyph_ink_metrics_unit_test;
  import gim_pkg::*;

  localparam logic [2:0] WidthRegAddr = {REG_GLYPH_WIDTH, 2'b00};
  localparam int RandomWords = 1650;

  // predicts the metrics of each glyph from the accepted bitmap words
  class glyph_scoreboard;
    logic [WidthBits-1:0] cell_width;
    int unsigned byte_slot;
    int unsigned ink_lo;
    int unsigned ink_hi;
    bit has_ink;
    glyph_res_t pending_metrics[$];
    int mismatch_cnt;
    int glyphs_checked;

    function new();
      mismatch_cnt = 0;
      glyphs_checked = 0;
      cell_width = WIDTH_RESET;
      clear_scan();
    endfunction

    function int unsigned used_width();
      return (cell_width > WIDTH_MAX) ? MaxWidth : cell_width;
    endfunction

    function int unsigned row_bytes();
      int unsigned n;
      n = (used_width() + 7) / 8;
      return (n == 0) ? 1 : n;
    endfunction

    function void clear_scan();
      byte_slot = 0;
      ink_lo = used_width();
      ink_hi = 0;
      has_ink = 0;
    endfunction

    function void set_width(logic [31:0] value);
      cell_width = value[WidthBits-1:0];
    endfunction

    function int pending();
      return pending_metrics.size();
    endfunction

    function void note_word(logic [7:0] pix, logic [20:0] cp, logic ok, logic last);
      int unsigned w;
      int unsigned rlen;
      int unsigned col;
      int unsigned span;
      int unsigned adv;
      int b;
      bit empty;
      bit ws;
      bit full;
      glyph_res_t res;
      w = used_width();
      rlen = row_bytes();
      if (byte_slot >= rlen) byte_slot = 0;
      for (b = 0; b < LaneCnt; b++) begin
        col = byte_slot * 8 + b;
        if (col < w && pix[7-b]) begin
          if (!has_ink || col < ink_lo) ink_lo = col;
          if (!has_ink || col > ink_hi) ink_hi = col;
          has_ink = 1;
        end
      end
      byte_slot++;
      if (byte_slot >= rlen) byte_slot = 0;
      if (!last) return;

      empty = !ok || !has_ink;
      ws = cp >= CP_WS_LO && cp <= CP_WS_HI;
      res.not_found = !ok || (empty && !ws && cp > CP_ASCII_HI);
      res.is_empty = empty;
      res.left_ink = '0;
      if (!empty) begin
        full = (cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
               (cp >= CP_KANA_LO && cp <= CP_KANA_HI) ||
               (cp >= CP_COMPAT_LO && cp <= CP_COMPAT_HI) ||
               (cp >= CP_FULL_LO && cp <= CP_FULL_HI);
        res.left_ink = ink_lo[ColBits-1:0];
        if (full) begin
          adv = w;
        end else begin
          span = ink_hi - ink_lo + 3;
          adv = (span > w) ? w : span;
        end
      end else if (ws) begin
        if (cp == CP_EM_SPACE) adv = w;
        else if (cp == CP_EN_SPACE) adv = w / 2;
        else if (cp == CP_IDEO_SPACE) adv = w;  // cannot hit inside the space range
        else adv = w / 3;
      end else begin
        adv = w / 3;
      end
      res.advance = adv[WidthBits-1:0];
      pending_metrics.push_back(res);
      clear_scan();
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
        mismatch_cnt++;
      end
    endfunction

    function void check_result(glyph_res_t got);
      glyph_res_t exp_r;
      if (pending_metrics.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, got);
        mismatch_cnt++;
        return;
      end
      exp_r = pending_metrics.pop_front();
      glyphs_checked++;
      compare_field("not_found", 32'(exp_r.not_found), 32'(got.not_found));
      compare_field("is_empty", 32'(exp_r.is_empty), 32'(got.is_empty));
      compare_field("left_ink", 32'(exp_r.left_ink), 32'(got.left_ink));
      compare_field("advance", 32'(exp_r.advance), 32'(got.advance));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pixel_byte;
  logic [20:0] in_code_point;
  logic        in_read_ok;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_not_found;
  logic        out_is_empty;
  logic [5:0]  out_left_ink;
  logic [6:0]  out_advance;

  glyph_scoreboard sb;
  bit calm;
  int words_sent;
  int width_writes;

  glyph_ink_metrics_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_byte(in_pixel_byte),
    .in_code_point(in_code_point),
    .in_read_ok(in_read_ok),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_not_found(out_not_found),
    .out_is_empty(out_is_empty),
    .out_left_ink(out_left_ink),
    .out_advance(out_advance)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 10);
  endfunction

  function automatic logic [20:0] pick_code_point();
    logic [20:0] edges[22];
    edges = '{CP_ASCII_HI, CP_ASCII_HI + 21'd1, CP_WS_LO - 21'd1, CP_WS_HI + 21'd1,
              CP_CJK_LO - 21'd1, CP_CJK_LO, CP_CJK_HI, CP_CJK_HI + 21'd1, CP_KANA_LO,
              CP_KANA_HI, CP_KANA_HI + 21'd1, CP_COMPAT_LO - 21'd1, CP_COMPAT_LO,
              CP_COMPAT_HI, CP_COMPAT_HI + 21'd1, CP_FULL_LO - 21'd1, CP_FULL_LO,
              CP_FULL_HI, CP_FULL_HI + 21'd1, CP_EM_SPACE, CP_EN_SPACE, 21'h10FFFF};
    case ($urandom_range(0, 9))
      0: return 21'($urandom_range(0, 127));
      1: return CP_WS_LO + 21'($urandom_range(0, 15));
      2: return edges[$urandom_range(0, 21)];
      3: return 21'($urandom_range(CP_CJK_LO, CP_CJK_HI));
      4: return 21'($urandom_range(CP_KANA_LO, CP_KANA_HI));
      5: return 21'($urandom_range(CP_COMPAT_LO, CP_COMPAT_HI));
      6: return 21'($urandom_range(CP_FULL_LO, CP_FULL_HI));
      default: return 21'($urandom_range(0, 21'h10FFFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_pixels(int mode);
    case (mode)
      0: return 8'h00;
      1: return ($urandom_range(0, 7) == 0) ? (8'h80 >> $urandom_range(0, 7)) : 8'h00;
      2: return 8'($urandom) & 8'($urandom);
      3: return 8'($urandom);
      default: return 8'hFF;
    endcase
  endfunction

  task automatic send_word(logic [7:0] pix, logic [20:0] cp, logic ok, logic last);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_byte <= pix;
    in_code_point <= cp;
    in_read_ok <= ok;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_word(pix, cp, ok, last);
    words_sent++;
  endtask

  // code point and read status only matter on the closing word
  task automatic send_glyph(logic [20:0] cp, logic ok, int n, int mode);
    int i;
    for (i = 0; i < n; i++) begin
      if (i == n - 1) send_word(pick_pixels(mode), cp, ok, 1'b1);
      else send_word(pick_pixels(mode), 21'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [31:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WidthRegAddr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_width(value);
    width_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // result side: check each accepted word, stall at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready)
        sb.check_result({out_not_found, out_is_empty, out_left_ink, out_advance});
      out_ready <= !take_break();
    end
  end

  initial begin
    #2_000_000;
    $display("glyph_ink_metrics_unit verification failed");
    $finish;
  end

  initial begin
    int phase;
    int target;
    int rlen;
    int n;
    int start_words;
    logic [31:0] widths[12];
    widths = '{8, 1, 64, 0, 13, 127, 32, 7, 65, 9, 100, 24};
    sb = new();
    calm = 0;
    words_sent = 0;
    width_writes = 0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_pixel_byte <= '0;
    in_code_point <= '0;
    in_read_ok <= 1'b0;
    in_last_byte <= 1'b0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width of 8
    send_word(8'h00, 21'h0, 1'b1, 1'b0);
    send_word(8'h18, 21'h0, 1'b1, 1'b0);
    send_word(8'hFF, 21'h00041, 1'b1, 1'b1);
    send_word(8'h00, 21'h00020, 1'b1, 1'b1);
    send_word(8'h00, CP_EM_SPACE, 1'b1, 1'b1);
    send_word(8'h00, CP_EN_SPACE, 1'b1, 1'b1);
    send_word(8'h00, CP_WS_HI, 1'b1, 1'b1);
    send_word(8'h00, CP_IDEO_SPACE, 1'b1, 1'b1);
    send_word(8'hFF, 21'h00041, 1'b0, 1'b1);   // failed read hides the ink
    send_word(8'h01, CP_CJK_HI, 1'b1, 1'b1);
    send_word(8'h18, CP_FULL_HI + 21'd1, 1'b1, 1'b1);
    send_word(8'h40, 21'h10FFFF, 1'b1, 1'b1);
    // saturated width, ink in the first and last bytes of the row
    write_width(32'd127);
    send_word(8'h80, 21'h0, 1'b1, 1'b0);
    repeat (6) send_word(8'h00, 21'h0, 1'b1, 1'b0);
    send_word(8'h02, CP_ASCII_HI, 1'b1, 1'b1);
    // pixels past the width are dropped
    write_width(32'd13);
    send_word(8'h07, 21'h0, 1'b1, 1'b0);
    send_word(8'hFF, CP_CJK_LO, 1'b1, 1'b1);
    // zero width never inks
    write_width(32'd0);
    send_word(8'hFF, 21'h00041, 1'b1, 1'b1);
    // width change between rows of one glyph
    write_width(32'd16);
    send_word(8'h00, 21'h0, 1'b1, 1'b0);
    send_word(8'h01, 21'h0, 1'b1, 1'b0);
    write_width(32'd8);
    send_word(8'h80, 21'h00041, 1'b1, 1'b1);

    start_words = words_sent;
    phase = 0;
    while (words_sent - start_words < RandomWords) begin
      write_width(phase < 12 ? widths[phase] : 32'($urandom_range(0, 127)));
      calm = (phase == 3 || phase == 4);
      target = words_sent + 140;
      while (words_sent < target) begin
        rlen = sb.row_bytes();
        n = rlen * $urandom_range(1, rlen > 4 ? 3 : 6);
        if ($urandom_range(0, 99) < 15) n = $urandom_range(1, 2 * rlen + 3);
        send_glyph(pick_code_point(), $urandom_range(0, 99) >= 10, n, $urandom_range(0, 4));
      end
      phase++;
    end
    calm = 0;
    settle();
    repeat (10) @(posedge clk);

    $display("sent %0d bitmap words over %0d width settings", words_sent, width_writes);
    $display("checked %0d glyph result words, %0d mismatches",
             sb.glyphs_checked, sb.mismatch_cnt);
    if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
      $display("glyph_ink_metrics_unit verification clean");
    end else begin
      $display("glyph_ink_metrics_unit verification failed");
    end
    $finish;
  end

endmodule
